[hw/rtl/cursor_mask_to_rgba_outline_core_macros.svh]
// Assertion helpers used by cmoc_seq.
`ifndef CURSOR_MASK_TO_RGBA_OUTLINE_CORE_MACROS_SVH
`define CURSOR_MASK_TO_RGBA_OUTLINE_CORE_MACROS_SVH

// same-cycle implication
`define CMOC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CMOC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/cmoc_pkg.sv]
`timescale 1ns / 1ps
package cmoc_pkg;

  localparam int unsigned DIM_W = 9;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef logic [1:0] cls_t;
  localparam cls_t CLS_CLEAR = 2'd0;
  localparam cls_t CLS_WHITE = 2'd1;
  localparam cls_t CLS_BLACK = 2'd2;

  localparam logic [1:0] CFG_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_OUTLINE = 2'd2;

  localparam logic [7:0] OPAQUE = 8'hff;

  typedef struct packed {
    cls_t cls;
    logic xor_seen;
  } cmoc_result_t;

endpackage

[hw/rtl/cmoc_store.sv]
`timescale 1ns / 1ps
module cmoc_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [1:0]    wdata_i,
  output logic [1:0]    rdata_o
);

  logic [1:0] mem [DEPTH];
  logic [1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/cmoc_seq.sv]
`timescale 1ns / 1ps
`include "cursor_mask_to_rgba_outline_core_macros.svh"
module cmoc_seq
  import cmoc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  parameter int unsigned AW         = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          command_i,
  input  logic          first_pixel_i,
  input  logic          and_bit_i,
  input  logic          xor_bit_i,
  input  logic [6:0]    read_x_i,
  input  logic [6:0]    read_y_i,
  input  logic [6:0]    width_i,
  input  logic [6:0]    height_i,
  input  logic          outline_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output cmoc_result_t  res_o,
  output logic          mem_en_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_addr_o,
  output logic [1:0]    mem_wdata_o,
  input  logic [1:0]    mem_rdata_i
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_READ,
    S_DRAIN,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  logic              flag_q, flag_d;
  cls_t              cent_q, cent_d;
  logic              any_q, any_d;
  logic signed [9:0] bx_q, bx_d;
  logic signed [9:0] by_q, by_d;
  logic [1:0]        ox_q, ox_d;
  logic [1:0]        oy_q, oy_d;
  logic              single_q, single_d;
  logic              pend_q, pend_d;
  logic              ctr_q, ctr_d;

  logic [DIM_W-1:0]  w_ext, h_ext;
  logic signed [9:0] px, py;
  logic              inb, is_ctr, vis, last_step;
  cls_t              load_cls;

  assign w_ext = DIM_W'(width_i);
  assign h_ext = DIM_W'(height_i);

  assign px = bx_q + $signed({8'b0, ox_q});
  assign py = by_q + $signed({8'b0, oy_q});
  assign inb = !px[9] && !py[9] && (px[8:0] < w_ext) && (py[8:0] < h_ext);
  assign is_ctr = single_q || (ox_q == 2'd1 && oy_q == 2'd1);
  assign last_step = single_q || (ox_q == 2'd2 && oy_q == 2'd2);
  assign vis = pend_q && (mem_rdata_i == CLS_WHITE || mem_rdata_i == CLS_BLACK);

  always_comb begin
    if (!and_bit_i) begin
      load_cls = xor_bit_i ? CLS_WHITE : CLS_BLACK;
    end else if (xor_bit_i) begin
      load_cls = CLS_BLACK;
    end else begin
      load_cls = CLS_CLEAR;
    end
  end

  always_comb begin
    state_d  = state_q;
    col_d    = col_q;
    row_d    = row_q;
    flag_d   = flag_q;
    cent_d   = cent_q;
    any_d    = any_q;
    bx_d     = bx_q;
    by_d     = by_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    single_d = single_q;
    pend_d   = pend_q;
    ctr_d    = ctr_q;

    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_en_o    = 1'b0;
    mem_we_o    = 1'b0;
    mem_addr_o  = AW'(py[8:0]) * AW'(MAX_WIDTH) + AW'(px[8:0]);
    mem_wdata_o = cent_q;

    // neighbor data returning from the store
    if (vis) begin
      any_d = 1'b1;
      if (ctr_q) begin
        cent_d = mem_rdata_i;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          any_d  = 1'b0;
          pend_d = 1'b0;
          ox_d   = 2'd0;
          oy_d   = 2'd0;
          if (command_i == CMD_LOAD) begin
            if (first_pixel_i) begin
              col_d  = '0;
              row_d  = '0;
              flag_d = 1'b0;
            end
            if (and_bit_i && xor_bit_i) begin
              flag_d = 1'b1;
            end
            cent_d  = load_cls;
            state_d = S_LOAD;
          end else begin
            cent_d = CLS_CLEAR;
            if (!outline_i) begin
              bx_d     = $signed({3'b0, read_x_i});
              by_d     = $signed({3'b0, read_y_i});
              single_d = 1'b1;
              state_d  = S_READ;
            end else if ((DIM_W'(read_x_i) < w_ext + DIM_W'(2)) &&
                         (DIM_W'(read_y_i) < h_ext + DIM_W'(2))) begin
              bx_d     = $signed({3'b0, read_x_i}) - 10'sd2;
              by_d     = $signed({3'b0, read_y_i}) - 10'sd2;
              single_d = 1'b0;
              state_d  = S_READ;
            end else begin
              state_d = S_DONE;
            end
          end
        end
      end
      S_LOAD: begin
        mem_addr_o = AW'(row_q) * AW'(MAX_WIDTH) + AW'(col_q);
        if (DIM_W'(row_q) < h_ext) begin
          mem_en_o = DIM_W'(col_q) < w_ext;
          mem_we_o = 1'b1;
          if (DIM_W'(col_q) + DIM_W'(1) >= w_ext) begin
            col_d = '0;
            row_d = row_q + RW'(1);
          end else begin
            col_d = col_q + CW'(1);
          end
        end
        state_d = S_DONE;
      end
      S_READ: begin
        mem_en_o = inb;
        pend_d   = inb;
        ctr_d    = is_ctr;
        if (last_step) begin
          state_d = S_DRAIN;
        end else if (ox_q == 2'd2) begin
          ox_d = 2'd0;
          oy_d = oy_q + 2'd1;
        end else begin
          ox_d = ox_q + 2'd1;
        end
      end
      S_DRAIN: begin
        pend_d  = 1'b0;
        state_d = S_DONE;
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.xor_seen = flag_q;
    if (cent_q != CLS_CLEAR) begin
      res_o.cls = cent_q;
    end else begin
      res_o.cls = any_q ? CLS_WHITE : CLS_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      flag_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      flag_q  <= flag_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cent_q   <= cent_d;
    any_q    <= any_d;
    bx_q     <= bx_d;
    by_q     <= by_d;
    ox_q     <= ox_d;
    oy_q     <= oy_d;
    single_q <= single_d;
    ctr_q    <= ctr_d;
  end

  `CMOC_ASSERT_IMP(a_write_in_area, mem_en_o && mem_we_o, DIM_W'(row_q) < h_ext)
  `CMOC_ASSERT_NXT(a_col_wraps, state_q == S_LOAD && DIM_W'(row_q) < h_ext, DIM_W'(col_q) < w_ext)
  `CMOC_ASSERT_NXT(a_plain_one_read, state_q == S_READ && single_q, state_q == S_DRAIN)
  `CMOC_ASSERT_IMP(a_no_pend_idle, state_q == S_IDLE || state_q == S_LOAD, !pend_q)

endmodule

[hw/rtl/cursor_mask_to_rgba_outline_core.sv]
`timescale 1ns / 1ps
// channel | direction | handshake              | word
// in      | input     | in_valid_i/in_ready_o  | command, first_pixel, and/xor bits, read_x/y
// out     | output    | out_valid_o/out_ready_i| red, green, blue, alpha, xor_seen
// cfg     | input     | cfg_we_i               | cfg_index_i, cfg_data_i
//
// One word in flight. Load: S_LOAD, then S_DONE to the output register. Plain read:
// S_READ, S_DRAIN, S_DONE. Outlined read: one stored neighbor read per cycle on the
// single-port class store (registered read data); outside the frame straight to S_DONE.
// Reset clears control and config only; the class store has no reset and no clearing pass.
// A result waiting in the output register does not stop the next word from starting.
module cursor_mask_to_rgba_outline_core
  import cmoc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [6:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       command_i,
  input  logic       first_pixel_i,
  input  logic       and_bit_i,
  input  logic       xor_bit_i,
  input  logic [6:0] read_x_i,
  input  logic [6:0] read_y_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic [7:0] alpha_o,
  output logic       xor_seen_o
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [6:0]   width_q, height_q;
  logic         outline_q;
  logic [6:0]   w_eff, h_eff;

  logic         res_valid, res_ready;
  cmoc_result_t res;
  logic         mem_en, mem_we;
  logic [AW-1:0] mem_addr;
  logic [1:0]   mem_wdata, mem_rdata;

  logic         out_valid_q, out_valid_d;
  logic [7:0]   color_q, alpha_q;
  logic         xor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 7'd32;
      height_q  <= 7'd32;
      outline_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WIDTH:   width_q   <= cfg_data_i;
        CFG_HEIGHT:  height_q  <= cfg_data_i;
        CFG_OUTLINE: outline_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == 7'd0) begin
      w_eff = 7'd1;
    end else if (DIM_W'(width_q) > DIM_W'(MAX_WIDTH)) begin
      w_eff = 7'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == 7'd0) begin
      h_eff = 7'd1;
    end else if (DIM_W'(height_q) > DIM_W'(MAX_HEIGHT)) begin
      h_eff = 7'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  cmoc_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .first_pixel_i (first_pixel_i),
    .and_bit_i     (and_bit_i),
    .xor_bit_i     (xor_bit_i),
    .read_x_i      (read_x_i),
    .read_y_i      (read_y_i),
    .width_i       (w_eff),
    .height_i      (h_eff),
    .outline_i     (outline_q),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_en_o      (mem_en),
    .mem_we_o      (mem_we),
    .mem_addr_o    (mem_addr),
    .mem_wdata_o   (mem_wdata),
    .mem_rdata_i   (mem_rdata)
  );

  cmoc_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      color_q <= (res.cls == CLS_WHITE) ? OPAQUE : 8'h00;
      alpha_q <= (res.cls == CLS_WHITE || res.cls == CLS_BLACK) ? OPAQUE : 8'h00;
      xor_q   <= res.xor_seen;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = color_q;
  assign green_o     = color_q;
  assign blue_o      = color_q;
  assign alpha_o     = alpha_q;
  assign xor_seen_o  = xor_q;

endmodule

[tb/sv/tb_cursor_mask_to_rgba_outline_core.sv]
`timescale 1ns / 1ps
module tb_cursor_mask_to_rgba_outline_core;
  import cmoc_pkg::*;

  localparam int TB_MAX_W    = 64;
  localparam int TB_MAX_H    = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam int WORD_TARGET = 850;

  typedef struct {
    bit       cmd;
    bit       first;
    bit       and_bit;
    bit       xor_bit;
    bit [6:0] x;
    bit [6:0] y;
  } cursor_word_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       xor_seen;
  } pixel_t;

  class cursor_scoreboard;
    cls_t        pix_cls[TB_MAX_H][TB_MAX_W];
    bit          loaded[TB_MAX_H][TB_MAX_W];
    bit [6:0]    width_reg;
    bit [6:0]    height_reg;
    bit          outline_on;
    int          load_col;
    int          load_row;
    bit          xor_flag;
    pixel_t      expected_q[$];
    int unsigned errors;

    function new();
      width_reg  = 7'd32;
      height_reg = 7'd32;
      outline_on = 1'b1;
      load_col   = 0;
      load_row   = 0;
      xor_flag   = 1'b0;
      errors     = 0;
      foreach (loaded[i, j]) begin
        loaded[i][j]  = 1'b0;
        pix_cls[i][j] = CLS_CLEAR;
      end
    endfunction

    function int eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > TB_MAX_W) return TB_MAX_W;
      return int'(width_reg);
    endfunction

    function int eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > TB_MAX_H) return TB_MAX_H;
      return int'(height_reg);
    endfunction

    function void set_register(logic [1:0] idx, logic [6:0] data);
      case (idx)
        CFG_WIDTH: begin
          width_reg = data;
        end
        CFG_HEIGHT: begin
          height_reg = data;
        end
        CFG_OUTLINE: begin
          outline_on = data[0];
        end
        default: ;
      endcase
    endfunction

    function bit in_area(int sx, int sy);
      return sx >= 0 && sy >= 0 && sx < eff_width() && sy < eff_height();
    endfunction

    function cls_t source_class(int sx, int sy);
      if (!in_area(sx, sy)) return CLS_CLEAR;
      if (pix_cls[sy][sx] == CLS_WHITE || pix_cls[sy][sx] == CLS_BLACK) return pix_cls[sy][sx];
      return CLS_CLEAR;
    endfunction

    // every in-area entry a read may touch has been loaded
    function bit read_is_legal(int x, int y);
      int dx, dy;
      if (!outline_on) return !in_area(x, y) || loaded[y][x];
      if (x >= eff_width() + 2 || y >= eff_height() + 2) return 1'b1;
      for (dy = -2; dy <= 0; dy++) begin
        for (dx = -2; dx <= 0; dx++) begin
          if (in_area(x + dx, y + dy) && !loaded[y + dy][x + dx]) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function cls_t read_class(int x, int y);
      cls_t c;
      int   dx, dy;
      if (!outline_on) return source_class(x, y);
      if (x >= eff_width() + 2 || y >= eff_height() + 2) return CLS_CLEAR;
      c = source_class(x - 1, y - 1);
      if (c == CLS_CLEAR) begin
        for (dy = -2; dy <= 0; dy++) begin
          for (dx = -2; dx <= 0; dx++) begin
            if (source_class(x + dx, y + dy) != CLS_CLEAR) c = CLS_WHITE;
          end
        end
      end
      return c;
    endfunction

    function void note_input(cursor_word_t w);
      cls_t   c;
      pixel_t p;
      int     wd, ht;
      wd = eff_width();
      ht = eff_height();
      if (w.cmd == CMD_LOAD) begin
        if (w.first) begin
          load_col = 0;
          load_row = 0;
          xor_flag = 1'b0;
        end
        if (!w.and_bit) begin
          c = w.xor_bit ? CLS_WHITE : CLS_BLACK;
        end else if (w.xor_bit) begin
          c = CLS_BLACK;
          xor_flag = 1'b1;
        end else begin
          c = CLS_CLEAR;
        end
        if (load_row < ht) begin
          if (load_col < wd) begin
            pix_cls[load_row][load_col] = c;
            loaded[load_row][load_col]  = 1'b1;
          end
          load_col++;
          if (load_col >= wd) begin
            load_col = 0;
            load_row++;
          end
        end
      end else begin
        c = read_class(int'(w.x), int'(w.y));
      end
      p.red      = (c == CLS_WHITE) ? OPAQUE : 8'h00;
      p.green    = p.red;
      p.blue     = p.red;
      p.alpha    = (c == CLS_WHITE || c == CLS_BLACK) ? OPAQUE : 8'h00;
      p.xor_seen = xor_flag;
      expected_q.push_back(p);
    endfunction

    task log_mismatch(string what);
      errors++;
      $display("%0t cmoc mismatch: %s", $time, what);
    endtask

    task check_result(pixel_t got);
      pixel_t want;
      if (expected_q.size() == 0) begin
        log_mismatch("output word with nothing pending");
        return;
      end
      want = expected_q.pop_front();
      if (got.red !== want.red)
        log_mismatch($sformatf("red %h, want %h", got.red, want.red));
      if (got.green !== want.green)
        log_mismatch($sformatf("green %h, want %h", got.green, want.green));
      if (got.blue !== want.blue)
        log_mismatch($sformatf("blue %h, want %h", got.blue, want.blue));
      if (got.alpha !== want.alpha)
        log_mismatch($sformatf("alpha %h, want %h", got.alpha, want.alpha));
      if (got.xor_seen !== want.xor_seen)
        log_mismatch($sformatf("xor_seen %b, want %b", got.xor_seen, want.xor_seen));
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [6:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       command_i;
  logic       first_pixel_i;
  logic       and_bit_i;
  logic       xor_bit_i;
  logic [6:0] read_x_i;
  logic [6:0] read_y_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] red_o;
  logic [7:0] green_o;
  logic [7:0] blue_o;
  logic [7:0] alpha_o;
  logic       xor_seen_o;

  cursor_scoreboard sb;
  bit               tx_burst;
  bit               rx_burst;
  int unsigned      and_pct;
  int unsigned      words_sent;
  int unsigned      cycle_count = 0;

  cursor_mask_to_rgba_outline_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .first_pixel_i(first_pixel_i),
    .and_bit_i    (and_bit_i),
    .xor_bit_i    (xor_bit_i),
    .read_x_i     (read_x_i),
    .read_y_i     (read_y_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_o      (alpha_o),
    .xor_seen_o   (xor_seen_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[cursor_mask_to_rgba_outline_core] ERROR");
      $finish;
    end
  end

  task automatic send_word(cursor_word_t w);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= w.cmd;
    first_pixel_i <= w.first;
    and_bit_i     <= w.and_bit;
    xor_bit_i     <= w.xor_bit;
    read_x_i      <= w.x;
    read_y_i      <= w.y;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_input(w);
    words_sent++;
  endtask

  task automatic send_load(bit first, bit a, bit xr);
    cursor_word_t w;
    w.cmd     = CMD_LOAD;
    w.first   = first;
    w.and_bit = a;
    w.xor_bit = xr;
    w.x       = 7'($urandom_range(0, 65));
    w.y       = 7'($urandom_range(0, 65));
    send_word(w);
  endtask

  task automatic send_read(bit [6:0] x, bit [6:0] y);
    cursor_word_t w;
    w.cmd     = CMD_READ;
    w.first   = 1'($urandom);
    w.and_bit = 1'($urandom);
    w.xor_bit = 1'($urandom);
    w.x       = x;
    w.y       = y;
    send_word(w);
  endtask

  task automatic send_random_load(bit first);
    send_load(first, $urandom_range(0, 99) < and_pct, 1'($urandom_range(0, 1)));
  endtask

  // falls back to a load when no read clear of unloaded entries turns up
  task automatic send_random_read();
    int wd, ht, x, y, k;
    bit ok;
    wd = sb.eff_width();
    ht = sb.eff_height();
    ok = 1'b0;
    for (k = 0; k < 16 && !ok; k++) begin
      if ($urandom_range(0, 9) < 7) begin
        x = $urandom_range(0, sb.outline_on ? wd + 1 : wd - 1);
        y = $urandom_range(0, sb.outline_on ? ht + 1 : ht - 1);
      end else begin
        x = $urandom_range(0, 65);
        y = $urandom_range(0, 65);
      end
      ok = sb.read_is_legal(x, y);
    end
    if (ok) send_read(7'(x), 7'(y));
    else send_random_load(1'b0);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic apply_config(bit [6:0] wv, bit [6:0] hv, bit om);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_WIDTH;
    cfg_data_i  <= wv;
    @(posedge clk_i);
    sb.set_register(CFG_WIDTH, wv);
    cfg_index_i <= CFG_HEIGHT;
    cfg_data_i  <= hv;
    @(posedge clk_i);
    sb.set_register(CFG_HEIGHT, hv);
    cfg_index_i <= CFG_OUTLINE;
    cfg_data_i  <= {6'd0, om};
    @(posedge clk_i);
    sb.set_register(CFG_OUTLINE, {6'd0, om});
    cfg_we_i <= 1'b0;
  endtask

  function automatic bit [6:0] extreme_size();
    case ($urandom_range(0, 2))
      0: return 7'd0;
      1: return 7'd64;
      default: return 7'd127;
    endcase
  endfunction

  task automatic run_phase();
    bit [6:0]    wv, hv;
    int unsigned area, n, extra, k, mode;
    case ($urandom_range(0, 11))
      0: begin
        wv = extreme_size();
        hv = 7'($urandom_range(1, 2));
      end
      1: begin
        wv = 7'($urandom_range(1, 2));
        hv = extreme_size();
      end
      2: begin
        wv = 7'($urandom_range(9, 20));
        hv = 7'($urandom_range(1, 4));
      end
      default: begin
        wv = 7'($urandom_range(1, 8));
        hv = 7'($urandom_range(1, 8));
      end
    endcase
    apply_config(wv, hv, 1'($urandom_range(0, 1)));
    tx_burst = ($urandom_range(0, 4) == 0);
    case ($urandom_range(0, 2))
      0: and_pct = 20;
      1: and_pct = 50;
      default: and_pct = 85;
    endcase
    area = sb.eff_width() * sb.eff_height();
    mode = $urandom_range(0, 9);
    if (mode < 8) begin
      // restart at the origin; mode 7 stops part way
      n = (mode == 7) ? $urandom_range(1, area) : area;
      for (k = 0; k < n; k++) send_random_load(k == 0);
    end else begin
      n = $urandom_range(0, area);
      for (k = 0; k < n; k++) send_random_load(1'b0);
    end
    extra = $urandom_range(10, 40);
    for (k = 0; k < extra; k++) begin
      if ($urandom_range(0, 6) == 0) send_random_load($urandom_range(0, 9) == 0);
      else send_random_read();
    end
  endtask

  initial begin : result_sink
    pixel_t      got;
    int unsigned stall;
    out_ready_i <= 1'b0;
    rx_burst = 1'b0;
    @(posedge clk_i);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got.red      = red_o;
      got.green    = green_o;
      got.blue     = blue_o;
      got.alpha    = alpha_o;
      got.xor_seen = xor_seen_o;
      sb.check_result(got);
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
    end
  end

  initial begin : stimulus
    sb = new();
    tx_burst   = 1'b0;
    and_pct    = 50;
    words_sent = 0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_WIDTH;
    cfg_data_i    <= 7'd0;
    in_valid_i    <= 1'b0;
    command_i     <= CMD_LOAD;
    first_pixel_i <= 1'b0;
    and_bit_i     <= 1'b0;
    xor_bit_i     <= 1'b0;
    read_x_i      <= 7'd0;
    read_y_i      <= 7'd0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_read(7'd65, 7'd65);
    apply_config(7'd2, 7'd2, 1'b1);
    send_load(1'b1, 1'b0, 1'b0);
    send_load(1'b0, 1'b0, 1'b1);
    send_load(1'b0, 1'b1, 1'b1);
    send_load(1'b0, 1'b1, 1'b0);
    // past the last row: converted but not stored
    send_load(1'b0, 1'b0, 1'b1);
    send_read(7'd0, 7'd0);
    send_read(7'd1, 7'd1);
    send_read(7'd2, 7'd2);
    send_read(7'd3, 7'd3);
    send_read(7'd3, 7'd0);
    send_read(7'd4, 7'd4);
    send_load(1'b1, 1'b1, 1'b0);
    send_read(7'd1, 7'd1);
    apply_config(7'd2, 7'd2, 1'b0);
    send_read(7'd0, 7'd0);
    send_read(7'd1, 7'd0);
    send_read(7'd2, 7'd0);
    send_read(7'd0, 7'd65);
    // width shrinks in the middle of a row
    apply_config(7'd4, 7'd2, 1'b1);
    send_load(1'b1, 1'b0, 1'b1);
    send_load(1'b0, 1'b0, 1'b0);
    send_load(1'b0, 1'b1, 1'b1);
    apply_config(7'd2, 7'd2, 1'b1);
    send_load(1'b0, 1'b0, 1'b1);
    send_load(1'b0, 1'b1, 1'b0);

    while (words_sent < WORD_TARGET) run_phase();

    settle();
    repeat (30) @(posedge clk_i);
    if (sb.errors == 0) $display("[cursor_mask_to_rgba_outline_core] OK");
    else $display("[cursor_mask_to_rgba_outline_core] ERROR");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/cmoc_pkg.sv
hw/rtl/cmoc_store.sv
hw/rtl/cmoc_seq.sv
hw/rtl/cursor_mask_to_rgba_outline_core.sv
tb/sv/tb_cursor_mask_to_rgba_outline_core.sv
